// ===== rtl/indexed_list_insert_delete_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list block
// Clocked, reset-qualified concurrent assertion shorthands.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define ILID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define ILID_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ilid_pkg.sv =====
// ---------------------------------------------------------------------------
// ilid_pkg
// Shared types, codes and widths of the indexed list block.
// ---------------------------------------------------------------------------
package ilid_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int ACT_W     = 2;
  localparam int IDX_W     = 8;
  localparam int TAG_W     = 2;
  localparam int DATA_W    = 64;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;

  // Operation codes
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOUNDS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  // One list entry as stored in memory
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } seq_state_t;

endpackage

// ===== rtl/indexed_list_insert_delete_top.sv =====
// ---------------------------------------------------------------------------
// indexed_list_insert_delete_top
// Ordered list of up to DEPTH tagged 64-bit entries with read, insert at
// index and delete at index.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a clock edge with start high and busy low;
//   in_action selects read, insert or delete at in_index. Each transaction
//   yields one result, shown for exactly one cycle with out_valid high:
//   out_status, out_tag/out_data (entry read or deleted, else zero) and
//   out_entry_count after the operation.
//   Sequence: rejected or no-op transactions strobe in the cycle after
//   accept. Insert reads entries from the last down to i, delete from i up
//   to the last, read only entry i; insert writes the new entry in S_FINISH.
//   Entries move one per cycle through the RAM's read port, each written by
//   the write port in the cycle after its read. busy is high until the
//   result strobes; a new transaction may start in the strobe cycle.
//   Reset empties the list (count 0); no memory clearing pass is needed.
//   The receiver cannot stall; every result must be taken when strobed.
// ---------------------------------------------------------------------------
module indexed_list_insert_delete_top #(
  parameter int DEPTH = ilid_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ilid_pkg::ACT_W-1:0]     in_action,
  input  logic [ilid_pkg::IDX_W-1:0]     in_index,
  input  logic [ilid_pkg::TAG_W-1:0]     in_value_tag,
  input  logic [ilid_pkg::DATA_W-1:0]    in_value_data,
  output logic                           out_valid,
  output logic [ilid_pkg::STAT_W-1:0]    out_status,
  output logic [ilid_pkg::TAG_W-1:0]     out_tag,
  output logic [ilid_pkg::DATA_W-1:0]    out_data,
  output logic [ilid_pkg::CNT_OUT_W-1:0] out_entry_count
);

  localparam int AW = $clog2(DEPTH);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  ilid_pkg::entry_t ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  ilid_pkg::entry_t ram_rdata;

  // sequencer
  ilid_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_index        (in_index),
    .in_value_tag    (in_value_tag),
    .in_value_data   (in_value_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_data        (out_data),
    .out_entry_count (out_entry_count),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  // entry store
  ilid_ram #(
    .WIDTH($bits(ilid_pkg::entry_t)),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== rtl/ilid_ram.sv =====
// ---------------------------------------------------------------------------
// ilid_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ilid_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ilid_seq.sv =====
// ---------------------------------------------------------------------------
// ilid_seq
// Operation sequencer: bounds checks, entry move pipeline over the RAM,
// entry count and result registers.
// ---------------------------------------------------------------------------
`include "indexed_list_insert_delete_top_assert.svh"

module ilid_seq #(
  parameter int DEPTH = ilid_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command
  input  logic                           start,
  output logic                           busy,
  input  logic [ilid_pkg::ACT_W-1:0]     in_action,
  input  logic [ilid_pkg::IDX_W-1:0]     in_index,
  input  logic [ilid_pkg::TAG_W-1:0]     in_value_tag,
  input  logic [ilid_pkg::DATA_W-1:0]    in_value_data,
  // result
  output logic                           out_valid,
  output logic [ilid_pkg::STAT_W-1:0]    out_status,
  output logic [ilid_pkg::TAG_W-1:0]     out_tag,
  output logic [ilid_pkg::DATA_W-1:0]    out_data,
  output logic [ilid_pkg::CNT_OUT_W-1:0] out_entry_count,
  // RAM
  output logic                           ram_we,
  output logic [$clog2(DEPTH)-1:0]       ram_waddr,
  output ilid_pkg::entry_t               ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(DEPTH)-1:0]       ram_raddr,
  input  ilid_pkg::entry_t               ram_rdata
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > ilid_pkg::IDX_W) ? CW : ilid_pkg::IDX_W;

  ilid_pkg::seq_state_t          state_r, state_nxt;
  logic [ilid_pkg::ACT_W-1:0]    op_r, op_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  ilid_pkg::entry_t              new_r, new_nxt;
  logic [AW-1:0]                 rp_r, rp_nxt;      // next read address
  logic                          rv_r, rv_nxt;      // read issued last cycle
  logic [AW-1:0]                 ra_r, ra_nxt;      // address of that read
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ilid_pkg::STAT_W-1:0]   status_r, status_nxt;
  ilid_pkg::entry_t              res_r, res_nxt;

  logic [CMPW-1:0] idx_w, cnt_w;
  logic [AW-1:0]   last_addr;
  logic            accept;
  logic            is_ins;

  assign idx_w     = CMPW'(in_index);
  assign cnt_w     = CMPW'(cnt_r);
  assign last_addr = AW'(cnt_r - CW'(1));
  assign accept    = start && (state_r == ilid_pkg::S_IDLE);
  assign is_ins    = (op_r == ilid_pkg::ACT_INSERT);

  // Sequencer. Reads stream one per cycle and return in the next cycle; the entry at
  // a read or delete index is kept as result, others move one place up (insert)
  // or down (delete). Reads run away from the writes, so the two ports never touch the same entry.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    rp_nxt        = rp_r;
    rv_nxt        = 1'b0;
    ra_nxt        = ra_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rp_r;

    // returning read data: captured as result or moved
    if (rv_r) begin
      if (!is_ins && (ra_r == idx_r)) begin
        res_nxt = ram_rdata;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = is_ins ? AW'(ra_r + AW'(1)) : AW'(ra_r - AW'(1));
      end
    end

    case (state_r)
      ilid_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt       = in_action;
          idx_nxt      = AW'(in_index);
          new_nxt.tag  = in_value_tag;
          new_nxt.data = in_value_data;
          status_nxt   = ilid_pkg::STAT_OK;
          res_nxt      = '0;
          case (in_action)
            ilid_pkg::ACT_READ, ilid_pkg::ACT_DELETE: begin
              if (idx_w >= cnt_w) begin
                status_nxt    = ilid_pkg::STAT_BOUNDS;
                out_valid_nxt = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_index);
                rv_nxt    = 1'b1;
                ra_nxt    = AW'(in_index);
                rp_nxt    = AW'(AW'(in_index) + AW'(1));
                if ((in_action == ilid_pkg::ACT_READ) || (idx_w + CMPW'(1) == cnt_w)) begin
                  state_nxt = ilid_pkg::S_DRAIN;
                end else begin
                  state_nxt = ilid_pkg::S_SCAN;
                end
              end
            end
            ilid_pkg::ACT_INSERT: begin
              if (idx_w > cnt_w) begin
                status_nxt    = ilid_pkg::STAT_BOUNDS;
                out_valid_nxt = 1'b1;
              end else if (cnt_r == CW'(DEPTH)) begin
                status_nxt    = ilid_pkg::STAT_FULL;
                out_valid_nxt = 1'b1;
              end else if (idx_w == cnt_w) begin
                state_nxt = ilid_pkg::S_FINISH;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = last_addr;
                rv_nxt    = 1'b1;
                ra_nxt    = last_addr;
                rp_nxt    = AW'(last_addr - AW'(1));
                if (last_addr == AW'(in_index)) begin
                  state_nxt = ilid_pkg::S_DRAIN;
                end else begin
                  state_nxt = ilid_pkg::S_SCAN;
                end
              end
            end
            default: begin
              // unused code: no-op transaction
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ilid_pkg::S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = rp_r;
        rv_nxt    = 1'b1;
        ra_nxt    = rp_r;
        rp_nxt    = is_ins ? AW'(rp_r - AW'(1)) : AW'(rp_r + AW'(1));
        if (is_ins ? (rp_r == idx_r) : (rp_r == last_addr)) begin
          state_nxt = ilid_pkg::S_DRAIN;
        end
      end
      ilid_pkg::S_DRAIN: begin
        // last read returns this cycle
        if (is_ins) begin
          state_nxt = ilid_pkg::S_FINISH;
        end else begin
          if (op_r == ilid_pkg::ACT_DELETE) begin
            cnt_nxt = CW'(cnt_r - CW'(1));
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ilid_pkg::S_IDLE;
        end
      end
      ilid_pkg::S_FINISH: begin
        // new entry goes into the opened slot
        ram_we        = 1'b1;
        ram_waddr     = idx_r;
        ram_wdata     = new_r;
        cnt_nxt       = CW'(cnt_r + CW'(1));
        out_valid_nxt = 1'b1;
        state_nxt     = ilid_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ilid_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilid_pkg::S_IDLE;
      rv_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    new_r    <= new_nxt;
    rp_r     <= rp_nxt;
    ra_r     <= ra_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  assign busy            = (state_r != ilid_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_tag         = res_r.tag;
  assign out_data        = res_r.data;
  assign out_entry_count = ilid_pkg::CNT_OUT_W'(cnt_r);

  // checks
  `ILID_ASSERT(a_cnt_range, cnt_r <= CW'(DEPTH), "entry count above depth")
  `ILID_ASSERT_NEVER(a_port_clash, ram_we && ram_re && (ram_waddr == ram_raddr), "RAM read and write hit one entry")
  `ILID_ASSERT(a_done_strobe, $fell(busy) |-> out_valid_r, "operation ended without result strobe")
  `ILID_ASSERT(a_reject_keeps, (out_valid_r && (status_r != ilid_pkg::STAT_OK)) |-> (cnt_r == $past(cnt_r)), "rejected transaction changed the count")

endmodule
